/* hdl/rc4_pkg.sv */
// Shared types and constants for the RC4 stream cipher unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package rc4_pkg;

  localparam int unsigned KEY_MAX_DEF = 256;
  localparam int unsigned PERM_DEPTH  = 256;
  localparam int unsigned BYTE_W      = 8;

  typedef enum logic [1:0] {
    OP_KEY_FRESH     = 2'd0,
    OP_KEY_RESHUFFLE = 2'd1,
    OP_DATA          = 2'd2
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic key_wr;      // store the incoming key byte
    logic clr_perm;    // return the permutation to identity
    logic sched_start; // begin the key schedule
    logic data_start;  // take a data byte and advance index i
    logic rd_p;        // read S[i] (and the key byte for the schedule)
    logic rd_j;        // update j and read S[j]
    logic wr_p;        // write S[i] = S[j] and read S[S[i] + S[j]]
    logic wr_j;        // write S[j] = old S[i]
    logic sched_next;  // advance the schedule round
    logic sched_end;   // finish the schedule
    logic out_load;    // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_round;
    logic out_blocked;
  } dp_sts_t;

endpackage

/* hdl/rc4_ctrl.sv */
// Controller state machine of the RC4 stream cipher unit.
// Depends on rc4_pkg; issues commands to rc4_dp and reads its status.
module rc4_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        operation_i,
  input  logic              last_key_i,
  output logic              in_stall_o,
  output rc4_pkg::dp_cmd_t  cmd_o,
  input  rc4_pkg::dp_sts_t  sts_i
);
  import rc4_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_P,
    ST_RD_J,
    ST_WR_P,
    ST_WR_J
  } state_e;

  state_e state_q, state_d;
  logic   sched_q, sched_d;
  op_e    op;

  assign op         = op_e'(operation_i);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    sched_d = sched_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_KEY_FRESH, OP_KEY_RESHUFFLE: begin
              cmd_o.key_wr = 1'b1;
              if (last_key_i) begin
                cmd_o.clr_perm    = (op == OP_KEY_FRESH);
                cmd_o.sched_start = 1'b1;
                sched_d           = 1'b1;
                state_d           = ST_RD_P;
              end
            end
            OP_DATA: begin
              cmd_o.data_start = 1'b1;
              cmd_o.rd_p       = 1'b1;
              sched_d          = 1'b0;
              state_d          = ST_RD_J;
            end
            default: ;
          endcase
        end
      end
      ST_RD_P: begin
        cmd_o.rd_p = 1'b1;
        state_d    = ST_RD_J;
      end
      ST_RD_J: begin
        cmd_o.rd_j = 1'b1;
        state_d    = ST_WR_P;
      end
      ST_WR_P: begin
        cmd_o.wr_p = 1'b1;
        state_d    = ST_WR_J;
      end
      ST_WR_J: begin
        cmd_o.wr_j = 1'b1;
        if (sched_q) begin
          cmd_o.sched_next = 1'b1;
          if (sts_i.last_round) begin
            cmd_o.sched_end = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            state_d = ST_RD_P;
          end
        end else if (!sts_i.out_blocked) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sched_q <= sched_d;
    end
  end

endmodule

/* hdl/rc4_dp.sv */
// Datapath of the RC4 stream cipher unit: permutation memory, key store,
// indices and the output register. Depends on rc4_pkg; driven by rc4_ctrl.
module rc4_dp #(
  parameter int unsigned KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rc4_pkg::dp_cmd_t            cmd_i,
  output rc4_pkg::dp_sts_t            sts_o,
  input  logic [rc4_pkg::BYTE_W-1:0]  byte_in_i,
  input  logic                        restart_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [rc4_pkg::BYTE_W-1:0]  byte_out_o
);
  import rc4_pkg::*;

  localparam int unsigned KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned LW = $clog2(KEY_MAX + 1);

  logic [BYTE_W-1:0]     perm_mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] perm_vld_q;
  logic [BYTE_W-1:0]     key_mem [KEY_MAX];

  logic [BYTE_W-1:0] idx_i_q, idx_j_q;
  logic [KW-1:0]     kidx_q;
  logic [LW-1:0]     key_len_q;
  logic              sched_q;
  logic [BYTE_W-1:0] data_q, sp_q, sj_q, t_q, key_rd_q;
  logic [BYTE_W-1:0] rd_data_q, rd_addr_q;
  logic              rd_vld_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] byte_out_q;

  logic [BYTE_W-1:0] p_data, perm_rd, key_add, j_new, t_new, ks;
  logic [BYTE_W-1:0] rd_addr, wr_addr, wr_data;
  logic              rd_en, wr_en, key_full, kidx_wrap;

  // An entry never written since the last identity reset reads as its address.
  assign perm_rd   = rd_vld_q ? rd_data_q : rd_addr_q;
  assign p_data    = restart_i ? BYTE_W'(1) : idx_i_q + BYTE_W'(1);
  assign key_add   = sched_q ? key_rd_q : '0;
  assign j_new     = idx_j_q + perm_rd + key_add;
  assign t_new     = sp_q + perm_rd;
  assign key_full  = (key_len_q == LW'(KEY_MAX));
  assign kidx_wrap = ((LW'(kidx_q) + LW'(1)) == key_len_q);

  assign rd_en   = cmd_i.rd_p | cmd_i.rd_j | cmd_i.wr_p;
  assign rd_addr = cmd_i.rd_p ? (cmd_i.data_start ? p_data : idx_i_q) :
                   cmd_i.rd_j ? j_new : t_new;
  assign wr_en   = cmd_i.wr_p | cmd_i.wr_j;
  assign wr_addr = cmd_i.wr_p ? idx_i_q : idx_j_q;
  assign wr_data = cmd_i.wr_p ? perm_rd : sp_q;

  // After the swap S[i] holds old S[j] and S[j] holds old S[i].
  assign ks = (t_q == idx_j_q) ? sp_q :
              (t_q == idx_i_q) ? sj_q : perm_rd;

  assign sts_o.last_round  = (idx_i_q == BYTE_W'(PERM_DEPTH - 1));
  assign sts_o.out_blocked = out_valid_q & out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign byte_out_o        = byte_out_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= perm_mem[rd_addr];
    end
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr && !key_full) begin
      key_mem[key_len_q[KW-1:0]] <= byte_in_i;
    end
    if (cmd_i.rd_p) begin
      key_rd_q <= key_mem[kidx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.data_start) begin
      data_q <= byte_in_i;
    end
    if (cmd_i.rd_j) begin
      sp_q <= perm_rd;
    end
    if (cmd_i.wr_p) begin
      sj_q <= perm_rd;
      t_q  <= t_new;
    end
    if (cmd_i.out_load) begin
      byte_out_q <= data_q ^ ks;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
      rd_addr_q   <= '0;
      idx_i_q     <= '0;
      idx_j_q     <= '0;
      kidx_q      <= '0;
      key_len_q   <= '0;
      sched_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_perm) begin
        perm_vld_q <= '0;
      end else if (wr_en) begin
        perm_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q  <= perm_vld_q[rd_addr];
        rd_addr_q <= rd_addr;
      end
      if (cmd_i.key_wr && !key_full) begin
        key_len_q <= key_len_q + LW'(1);
      end
      if (cmd_i.sched_start) begin
        idx_i_q <= '0;
        idx_j_q <= '0;
        kidx_q  <= '0;
        sched_q <= 1'b1;
      end
      if (cmd_i.data_start) begin
        idx_i_q <= p_data;
        if (restart_i) begin
          idx_j_q <= '0;
        end
        sched_q <= 1'b0;
      end
      if (cmd_i.rd_j) begin
        idx_j_q <= j_new;
      end
      if (cmd_i.sched_next) begin
        idx_i_q <= idx_i_q + BYTE_W'(1);
        kidx_q  <= kidx_wrap ? '0 : kidx_q + KW'(1);
      end
      if (cmd_i.sched_end) begin
        idx_j_q   <= '0;
        key_len_q <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* hdl/rc4_stream_cipher_unit.sv */
// RC4 stream cipher unit. A data byte runs through the four-step permutation round, and
// the next transfer is taken only once its result is loaded into the output register.
// A non-final key byte is stored without stalling; the last key byte adds the 256-round
// key schedule, and no transfer is taken before the schedule ends.
// rst_ni (asynchronous, active low) sets the permutation to identity at once
// through per-entry valid bits, with no clearing pass, and clears the indices.
module rc4_stream_cipher_unit #(
  parameter int unsigned KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic [rc4_pkg::BYTE_W-1:0]  byte_in_i,
  input  logic                        last_key_i,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rc4_pkg::BYTE_W-1:0]  byte_out_o
);
  import rc4_pkg::*;

  // The controller sequences each permutation round in four steps: read S[i],
  // update j and read S[j], write S[i] while reading the keystream entry, and
  // write S[j] while the result is loaded into the output register. The key
  // schedule reuses the same round with the key byte added to j.
  dp_cmd_t cmd;
  dp_sts_t sts;

  rc4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .last_key_i  (last_key_i),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The output register parts the two sides, so a new transfer is taken while
  // a result still waits; a finished data byte waits only for that register.
  rc4_dp #(
    .KEY_MAX (KEY_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .byte_in_i   (byte_in_i),
    .restart_i   (restart_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .byte_out_o  (byte_out_o)
  );

endmodule

/* hdl/rc4_checker.sv */
// Port-level checks for the RC4 stream cipher unit, bound to the top level.
// Depends on rc4_pkg for the operation codes.
module rc4_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] operation_i,
  input logic       last_key_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] byte_out_o
);
  import rc4_pkg::*;

  logic acc_data, acc_key_mid;

  assign acc_data    = in_valid_i && !in_stall_o && (operation_i == OP_DATA);
  assign acc_key_mid = in_valid_i && !in_stall_o && !last_key_i &&
                       ((operation_i == OP_KEY_FRESH) || (operation_i == OP_KEY_RESHUFFLE));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_out_o))
    else $error("stalled result changed");

  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_data |=> in_stall_o)
    else $error("data transfer did not occupy the unit");

  a_key_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_key_mid |=> !in_stall_o)
    else $error("non-final key byte stalled the unit");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(acc_data, 4))
    else $error("result appeared without a data transfer four cycles earlier");

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (.*);
